FILE: hw/rtl/first_fit_extent_allocator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the extent allocator
// Clocked checks on clk, switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication
`define FFEA_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define FFEA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/ffea_pkg.sv
// ----------------------------------------------------------------------------
// ffea_pkg
// Types and constants shared by the extent allocator and its table cells.
// ----------------------------------------------------------------------------
package ffea_pkg;

  localparam int NUM_EXTENTS  = 16;
  localparam int HEADER_BYTES = 24;
  localparam int ADDR_W       = 32;
  localparam int IDX_W        = $clog2(NUM_EXTENTS);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // configuration register byte addresses
  localparam logic [2:0] REG_BASE  = 3'd0;
  localparam logic [2:0] REG_LIMIT = 3'd4;

  typedef enum logic [2:0] {
    ST_TABLE = 3'd0,
    ST_GROWN = 3'd1,
    ST_FREED = 3'd2,
    ST_FULL  = 3'd3,
    ST_LIMIT = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SHL,
    OP_INS,
    OP_WRITE,
    OP_MERGE
  } op_t;

  typedef struct packed {
    logic              cmd;
    logic [31:0]       request_size;
    logic [31:0]       block_address;
    logic [31:0]       block_length;
  } in_item_t;

  typedef struct packed {
    logic [31:0]       result_address;
    logic [31:0]       granted_length;
    logic [2:0]        status;
    logic [31:0]       segment_size;
    logic [31:0]       free_space;
  } out_item_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] start;
    logic [31:0]       len;
  } ext_t;

  typedef struct packed {
    op_t               op;
    logic [IDX_W-1:0]  k;
    logic [ADDR_W-1:0] wr_start;
    logic [31:0]       wr_len;
    logic [31:0]       size_key;
    logic [ADDR_W-1:0] hdr_key;
  } cell_ctl_t;

endpackage

FILE: hw/rtl/ffea_cell.sv
// ----------------------------------------------------------------------------
// ffea_cell
// One row entry: holds a free extent, compares it against the broadcast keys
// and on command shifts to or from its neighbours, is written or merges.
// ----------------------------------------------------------------------------
module ffea_cell
  import ffea_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] idx,
  input  cell_ctl_t        ctl,
  input  ext_t             left,
  input  ext_t             right,
  output ext_t             cur,
  output logic             fit,
  output logic             after,
  output logic             adj
);

  logic              valid_r;
  logic [ADDR_W-1:0] start_r;
  logic [31:0]       len_r;
  ext_t              cur_nxt;
  logic              at_k;
  logic              past_k;
  logic [ADDR_W-1:0] end_addr;

  assign cur      = '{valid: valid_r, start: start_r, len: len_r};
  assign at_k     = (idx == ctl.k);
  assign past_k   = (idx > ctl.k);
  assign end_addr = start_r + ADDR_W'(HEADER_BYTES) + ADDR_W'(len_r);

  assign fit   = valid_r && (ctl.size_key <= len_r);
  assign after = !valid_r || (start_r > ctl.hdr_key);
  assign adj   = valid_r && right.valid && (end_addr == right.start);

  always_comb begin
    cur_nxt = cur;
    unique case (ctl.op)
      OP_HOLD: ;
      OP_SHL: begin
        if (at_k || past_k) cur_nxt = right;
      end
      OP_INS: begin
        if (at_k) begin
          cur_nxt = '{valid: 1'b1, start: ctl.wr_start, len: ctl.wr_len};
        end else if (past_k) begin
          cur_nxt = left;
        end
      end
      OP_WRITE: begin
        if (at_k) begin
          cur_nxt.start = ctl.wr_start;
          cur_nxt.len   = ctl.wr_len;
        end
      end
      OP_MERGE: begin
        // absorb the right neighbour and close the gap behind it
        if (at_k) begin
          cur_nxt.len = len_r + right.len + 32'(HEADER_BYTES);
        end else if (past_k) begin
          cur_nxt = right;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cur_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    start_r <= cur_nxt.start;
    len_r   <= cur_nxt.len;
  end

endmodule

FILE: hw/rtl/first_fit_extent_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_extent_allocator
// First-fit allocator over an address-ordered row of free extents.
// ----------------------------------------------------------------------------
// One request at a time: an allocate moves from S_DECIDE to S_DONE, a free
// with room in the row also passes S_PRED and S_SUCC, staying in S_SUCC while
// it coalesces with successors. The row of extent cells changes by at most one
// shift, insert, split or merge per cycle. A result waits in its output
// register while the next item is accepted. Outputs of every request carry
// the segment size and the running total of free bytes (headers included).
module first_fit_extent_allocator
  import ffea_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "first_fit_extent_allocator_assert.svh"

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_PRED,
    S_SUCC,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic              cmd_r;
  logic [31:0]       size_r;
  logic [ADDR_W-1:0] hdr_r;
  logic [31:0]       blen_r;
  logic [IDX_W-1:0]  k_r, k_nxt;
  logic [31:0]       raddr_r, raddr_nxt;
  logic [31:0]       glen_r, glen_nxt;
  status_t           status_r, status_nxt;
  logic [31:0]       grown_r, grown_nxt;
  logic [31:0]       fs_r, fs_nxt;
  logic [31:0]       base_r, limit_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  cell_ctl_t         ctl;
  ext_t              cells [NUM_EXTENTS];
  logic [NUM_EXTENTS-1:0] fit_v, after_v, adj_v, valid_v;
  logic [NUM_EXTENTS-1:0] fit_first, ins_first;
  logic [IDX_W-1:0]  sel_idx, ins_idx;
  ext_t              sel;
  logic [31:0]       extra;
  logic [33:0]       grow_sum;
  logic              in_acc;

  // cell row
  for (genvar g = 0; g < NUM_EXTENTS; g++) begin : g_cell
    ext_t lft, rgt;
    if (g == 0) begin : g_first
      assign lft = '0;
    end else begin : g_mid
      assign lft = cells[g-1];
    end
    if (g == NUM_EXTENTS - 1) begin : g_last
      assign rgt = '0;
    end else begin : g_nlast
      assign rgt = cells[g+1];
    end
    ffea_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .idx   (IDX_W'(g)),
      .ctl   (ctl),
      .left  (lft),
      .right (rgt),
      .cur   (cells[g]),
      .fit   (fit_v[g]),
      .after (after_v[g]),
      .adj   (adj_v[g])
    );
    assign valid_v[g] = cells[g].valid;
  end

  // lowest set bit picks the first fit and the insertion point
  assign fit_first = fit_v & (~fit_v + 1'b1);
  assign ins_first = after_v & (~after_v + 1'b1);

  always_comb begin
    sel_idx = '0;
    ins_idx = '0;
    sel     = '0;
    for (int i = 0; i < NUM_EXTENTS; i++) begin
      if (fit_first[i]) begin
        sel_idx = sel_idx | IDX_W'(i);
        sel     = sel | cells[i];
      end
      if (ins_first[i]) ins_idx = ins_idx | IDX_W'(i);
    end
  end

  assign extra    = sel.len - size_r;
  assign grow_sum = {2'b00, grown_r} + 34'(HEADER_BYTES) + {2'b00, size_r};
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    ctl          = '{op: OP_HOLD, k: k_r, wr_start: '0, wr_len: '0,
                     size_key: size_r, hdr_key: hdr_r};
    state_nxt    = state_r;
    k_nxt        = k_r;
    raddr_nxt    = raddr_r;
    glen_nxt     = glen_r;
    status_nxt   = status_r;
    grown_nxt    = grown_r;
    fs_nxt       = fs_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        raddr_nxt = '0;
        glen_nxt  = '0;
        state_nxt = S_DONE;
        if (cmd_r == CMD_ALLOC) begin
          if (|fit_v) begin
            status_nxt = ST_TABLE;
            raddr_nxt  = 32'(ADDR_W'(sel.start + ADDR_W'(HEADER_BYTES)));
            ctl.k      = sel_idx;
            if (extra > 32'(HEADER_BYTES)) begin
              // split: the tail stays free under a fresh header
              ctl.op       = OP_WRITE;
              ctl.wr_start = sel.start + ADDR_W'(HEADER_BYTES) + ADDR_W'(size_r);
              ctl.wr_len   = extra - 32'(HEADER_BYTES);
              glen_nxt     = size_r;
              fs_nxt       = fs_r - size_r - 32'(HEADER_BYTES);
            end else begin
              ctl.op   = OP_SHL;
              glen_nxt = sel.len;
              fs_nxt   = fs_r - sel.len - 32'(HEADER_BYTES);
            end
          end else if (grow_sum > {2'b00, limit_r}) begin
            status_nxt = ST_LIMIT;
          end else begin
            status_nxt = ST_GROWN;
            raddr_nxt  = 32'(ADDR_W'(ADDR_W'(base_r) + ADDR_W'(grown_r)
                                     + ADDR_W'(HEADER_BYTES)));
            glen_nxt   = size_r;
            grown_nxt  = grow_sum[31:0];
          end
        end else if (valid_v[NUM_EXTENTS-1]) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt   = ST_FREED;
          ctl.op       = OP_INS;
          ctl.k        = ins_idx;
          ctl.wr_start = hdr_r;
          ctl.wr_len   = blen_r;
          k_nxt        = ins_idx;
          fs_nxt       = fs_r + blen_r + 32'(HEADER_BYTES);
          state_nxt    = S_PRED;
        end
      end
      S_PRED: begin
        state_nxt = S_SUCC;
        if (k_r != '0 && adj_v[k_r - 1'b1]) begin
          ctl.op = OP_MERGE;
          ctl.k  = k_r - 1'b1;
          k_nxt  = k_r - 1'b1;
        end
      end
      S_SUCC: begin
        // keep absorbing successors until the next one is not adjacent
        if (adj_v[k_r]) begin
          ctl.op = OP_MERGE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      grown_r     <= '0;
      fs_r        <= '0;
      k_r         <= '0;
      status_r    <= ST_TABLE;
    end else begin
      state_r  <= state_nxt;
      grown_r  <= grown_nxt;
      fs_r     <= fs_nxt;
      k_r      <= k_nxt;
      status_r <= status_nxt;
      if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
        out_data_r  <= '{result_address: raddr_r, granted_length: glen_r,
                         status: status_r, segment_size: grown_r,
                         free_space: fs_r};
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    raddr_r <= raddr_nxt;
    glen_r  <= glen_nxt;
    if (in_acc) begin
      cmd_r  <= in_data.cmd;
      size_r <= in_data.request_size;
      hdr_r  <= ADDR_W'(in_data.block_address) - ADDR_W'(HEADER_BYTES);
      blen_r <= in_data.block_length;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      limit_r <= '1;
    end else if (psel && penable && pwrite) begin
      if (paddr == REG_BASE)  base_r  <= pwdata;
      if (paddr == REG_LIMIT) limit_r <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_BASE)  prdata = base_r;
    if (paddr == REG_LIMIT) prdata = limit_r;
  end

  assign pready    = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `FFEA_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted item did not stall input")
  `FFEA_ASSERT(a_row_packed, 1'b1, $onehot({1'b0, valid_v} + 1'b1), "extent row not packed from entry 0")
  `FFEA_ASSERT(a_status_code, out_valid, out_data.status <= ST_LIMIT, "undefined status code")

endmodule
